>>> design/rrt_pkg.sv
package rrt_pkg;

    localparam int ENTRIES_DEF       = 8;
    localparam int INTERVAL_BITS_DEF = 16;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_RESP   = 3'd1,
        OP_TICK   = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_HALT   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        K_TRANSMIT  = 3'd0,
        K_PARKED    = 3'd1,
        K_FULL      = 3'd2,
        K_MATCHED   = 3'd3,
        K_UNMATCHED = 3'd4,
        K_GAVE_UP   = 3'd5,
        K_CLEARED   = 3'd6,
        K_DONE      = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT,
        S_WAIT
    } t_state;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] msg_type;
        logic [7:0] seq_num;
        logic [3:0] max_count;
        logic [15:0] interval;
        logic       halt_enable;
    } t_req;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_msg_type;
        logic [7:0] out_seq_num;
        logic [3:0] out_count;
        logic       last;
    } t_rsp;

endpackage

>>> design/rrt_if.sv
interface rrt_req_if;
    import rrt_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rrt_rsp_if;
    import rrt_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> design/request_retransmit_table_unit.sv
// Retransmit table of pending requests.
// i_req carries one request per handshake (op, type, sequence number, limit,
// interval, halt flag). o_rsp carries the results, the final one with last set.
// A sequencer walks the slot array one slot per cycle, held while a result waits
// untaken, through a single shared compare/decrement unit, and every result waits
// in the output register. Add and response stop at the first slot that fits.
// Clear, set halt and a halt request with no change do not walk the slots.
// Tick and resume visit every slot, stalled while the receiver holds off a result.
// Requests are refused while a request is in progress, so the block handles
// one request at a time.
// A stalled receiver holds the walk on the current slot until the result is
// taken; nothing is lost or repeated.
// Reset empties the table, disarms all timers and sets halted. The slot
// storage itself is not cleared; only the valid and armed bits are.
// Ops 5 to 7 are dropped without a result.
// Requests with op 3 (clear) free all slots when they are accepted.
module request_retransmit_table_unit #(
    parameter int ENTRIES       = rrt_pkg::ENTRIES_DEF,
    parameter int INTERVAL_BITS = rrt_pkg::INTERVAL_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    rrt_req_if.sink   i_req,
    rrt_rsp_if.source o_rsp
);
    import rrt_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW:0] LAST_IDX = (IW+1)'(ENTRIES - 1);

    logic [ENTRIES-1:0] r_valid, n_valid, r_armed, n_armed;
    logic [7:0]  m_type  [ENTRIES];
    logic [7:0]  m_seq   [ENTRIES];
    logic [3:0]  m_count [ENTRIES];
    logic [3:0]  m_limit [ENTRIES];
    logic [INTERVAL_BITS-1:0] m_iv  [ENTRIES];
    logic [INTERVAL_BITS-1:0] m_rem [ENTRIES];

    logic   r_halted, n_halted;
    t_state r_state, n_state;
    t_req   r_req, n_req;
    logic [IW:0] r_idx, n_idx;
    t_rsp   r_out, n_out;
    logic   r_ov, n_ov;

    // Slot write port, driven by the sequencer.
    logic        w_en;
    logic [IW-1:0] w_addr;
    logic [7:0]  w_type, w_seq;
    logic [3:0]  w_count, w_limit;
    logic [INTERVAL_BITS-1:0] w_iv, w_rem;

    logic [IW-1:0] cur;
    logic [7:0]  c_type, c_seq;
    logic [3:0]  c_count, c_limit;
    logic [INTERVAL_BITS-1:0] c_iv, c_rem;
    logic [7:0]  want_type;
    logic [INTERVAL_BITS-1:0] in_iv;

    assign cur     = r_idx[IW-1:0];
    assign c_type  = m_type[cur];
    assign c_seq   = m_seq[cur];
    assign c_count = m_count[cur];
    assign c_limit = m_limit[cur];
    assign c_iv    = m_iv[cur];
    assign c_rem   = m_rem[cur];
    assign want_type = r_req.msg_type - 8'd1;
    assign in_iv = INTERVAL_BITS'({{(INTERVAL_BITS > 16 ? INTERVAL_BITS-16 : 1){1'b0}},
                                   r_req.interval});

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_ov;
    assign o_rsp.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            m_type[w_addr]  <= w_type;
            m_seq[w_addr]   <= w_seq;
            m_count[w_addr] <= w_count;
            m_limit[w_addr] <= w_limit;
            m_iv[w_addr]    <= w_iv;
            m_rem[w_addr]   <= w_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_armed  <= '0;
            r_halted <= 1'b1;
            r_ov     <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_armed  <= n_armed;
            r_halted <= n_halted;
            r_ov     <= n_ov;
            r_idx    <= n_idx;
        end
        r_req <= n_req;
        r_out <= n_out;
    end

    function automatic t_rsp mk(t_kind k, logic [7:0] t, logic [7:0] s,
                                logic [3:0] c, logic l);
        t_rsp r;
        r.kind = k; r.out_msg_type = t; r.out_seq_num = s;
        r.out_count = c; r.last = l;
        return r;
    endfunction

    always_comb begin
        logic slot_end;
        logic [3:0] inc;
        n_state  = r_state;
        n_valid  = r_valid;
        n_armed  = r_armed;
        n_halted = r_halted;
        n_req    = r_req;
        n_idx    = r_idx;
        n_out    = r_out;
        n_ov     = r_ov;
        w_en = 1'b0; w_addr = cur;
        w_type = c_type; w_seq = c_seq; w_count = c_count; w_limit = c_limit;
        w_iv = c_iv; w_rem = c_rem;
        slot_end = (r_idx == LAST_IDX);
        inc = c_count + 4'd1;

        if (r_ov && o_rsp.ready) n_ov = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req = i_req.payload;
                    n_idx = '0;
                    n_state = S_SCAN;
                    if (i_req.payload.op == OP_HALT) begin
                        if (r_halted == i_req.payload.halt_enable ||
                            i_req.payload.halt_enable) begin
                            n_halted = i_req.payload.halt_enable;
                            n_state = S_EMIT;
                        end else begin
                            n_halted = 1'b0;
                        end
                    end else if (i_req.payload.op == OP_CLEAR) begin
                        n_valid = '0; n_armed = '0;
                        n_state = S_WAIT;
                        n_ov = 1'b1;
                        n_out = mk(K_CLEARED, 8'd0, 8'd0, 4'd0, 1'b1);
                    end else if (i_req.payload.op != OP_ADD &&
                                 i_req.payload.op != OP_RESP &&
                                 i_req.payload.op != OP_TICK) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SCAN: begin
                // One slot per cycle, stalled until the output register is free.
                if (!(r_ov && !o_rsp.ready)) begin
                    case (r_req.op)
                        OP_ADD: begin
                            if (!r_valid[cur]) begin
                                n_valid[cur] = 1'b1;
                                n_armed[cur] = !r_halted;
                                w_en = 1'b1;
                                w_type = r_req.msg_type; w_seq = r_req.seq_num;
                                w_limit = r_req.max_count; w_iv = in_iv;
                                w_count = r_halted ? 4'd0 : 4'd1;
                                w_rem = r_halted ? '0 : in_iv;
                                n_ov = 1'b1; n_state = S_WAIT;
                                n_out = r_halted ?
                                    mk(K_PARKED, r_req.msg_type, r_req.seq_num, 4'd0, 1'b1) :
                                    mk(K_TRANSMIT, r_req.msg_type, r_req.seq_num, 4'd1, 1'b1);
                            end else if (slot_end) begin
                                n_ov = 1'b1; n_state = S_WAIT;
                                n_out = mk(K_FULL, r_req.msg_type, r_req.seq_num,
                                           4'd0, 1'b1);
                            end
                        end
                        OP_RESP: begin
                            if (r_req.msg_type != 8'd0 && r_valid[cur] &&
                                c_type == want_type && c_seq == r_req.seq_num) begin
                                n_valid[cur] = 1'b0; n_armed[cur] = 1'b0;
                                n_ov = 1'b1; n_state = S_WAIT;
                                n_out = mk(K_MATCHED, c_type, c_seq, c_count, 1'b1);
                            end else if (slot_end) begin
                                n_ov = 1'b1; n_state = S_WAIT;
                                n_out = mk(K_UNMATCHED,
                                           (r_req.msg_type != 8'd0) ? want_type : 8'd0,
                                           r_req.seq_num, 4'd0, 1'b1);
                            end
                        end
                        OP_TICK: begin
                            if (r_valid[cur] && r_armed[cur]) begin
                                w_en = 1'b1;
                                if (c_rem > INTERVAL_BITS'(1)) begin
                                    w_rem = c_rem - INTERVAL_BITS'(1);
                                end else if (c_count >= c_limit) begin
                                    n_valid[cur] = 1'b0; n_armed[cur] = 1'b0;
                                    n_ov = 1'b1;
                                    n_out = mk(K_GAVE_UP, c_type, c_seq, c_count, 1'b0);
                                end else if (r_halted) begin
                                    n_armed[cur] = 1'b0;
                                    n_ov = 1'b1;
                                    n_out = mk(K_PARKED, c_type, c_seq, c_count, 1'b0);
                                end else begin
                                    w_count = inc; w_rem = c_iv;
                                    n_ov = 1'b1;
                                    n_out = mk(K_TRANSMIT, c_type, c_seq, inc, 1'b0);
                                end
                            end
                            n_idx = r_idx + 1'b1;
                            if (slot_end) n_state = S_EMIT;
                        end
                        default: begin
                            // Resume: send parked entries under their limit, arm all.
                            if (r_valid[cur] && !r_armed[cur]) begin
                                w_en = 1'b1;
                                n_armed[cur] = 1'b1;
                                w_rem = c_iv;
                                if (c_count < c_limit) begin
                                    w_count = inc;
                                    n_ov = 1'b1;
                                    n_out = mk(K_TRANSMIT, c_type, c_seq, inc, 1'b0);
                                end
                            end
                            n_idx = r_idx + 1'b1;
                            if (slot_end) n_state = S_EMIT;
                        end
                    endcase
                    if (r_req.op == OP_ADD || r_req.op == OP_RESP) begin
                        if (n_state == S_SCAN) n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_EMIT: begin
                if (!(r_ov && !o_rsp.ready)) begin
                    n_ov = 1'b1; n_state = S_WAIT;
                    n_out = mk(K_DONE, 8'd0, 8'd0, 4'd0, 1'b1);
                end
            end
            S_WAIT: begin
                if (!n_ov) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

>>> bench/request_retransmit_table_unit_tb.sv
`timescale 1ns / 1ps

module request_retransmit_table_unit_tb;
    import rrt_pkg::*;

    localparam int NSLOT = ENTRIES_DEF;

    logic i_clk;
    logic i_rst_n;

    rrt_req_if req_ch ();
    rrt_rsp_if rsp_ch ();

    request_retransmit_table_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Predicted copy of the table.
    logic        tbl_valid [NSLOT];
    logic [7:0]  tbl_type  [NSLOT];
    logic [7:0]  tbl_seq   [NSLOT];
    logic [3:0]  tbl_count [NSLOT];
    logic [3:0]  tbl_limit [NSLOT];
    logic [15:0] tbl_ival  [NSLOT];
    logic [15:0] tbl_left  [NSLOT];
    logic        tbl_armed [NSLOT];
    logic        tbl_halted;

    t_rsp expected_rsps[$];
    int   mismatches;
    int   rsp_seen;
    int   req_sent;
    int   rsp_idle;      // cycles left in a receiver idle burst
    bit   calm;          // no idling in the final part
    bit   hold_rsp;      // long receiver stall
    bit   in_reset;

    task automatic report_mismatch(input string what, input t_rsp got, input t_rsp want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic t_rsp mk(input t_kind k, input int mt, input int sq,
                                input int c, input int l);
        t_rsp r;
        r.kind = k;
        r.out_msg_type = 8'(mt);
        r.out_seq_num = 8'(sq);
        r.out_count = 4'(c);
        r.last = 1'(l);
        return r;
    endfunction

    task automatic table_reset();
        for (int i = 0; i < NSLOT; i++) begin
            tbl_valid[i] = 0;
            tbl_armed[i] = 0;
            tbl_type[i] = 0;
            tbl_seq[i] = 0;
            tbl_count[i] = 0;
            tbl_limit[i] = 0;
            tbl_ival[i] = 0;
            tbl_left[i] = 0;
        end
        tbl_halted = 1;
    endtask

    task automatic predict_table(input t_req q);
        int i;
        bit hit;
        hit = 0;
        case (q.op)
            OP_ADD: begin
                for (i = 0; i < NSLOT; i++)
                    if (!tbl_valid[i]) break;
                if (i == NSLOT) begin
                    expected_rsps.push_back(mk(K_FULL, q.msg_type, q.seq_num, 0, 1));
                end else begin
                    tbl_valid[i] = 1;
                    tbl_type[i] = q.msg_type;
                    tbl_seq[i] = q.seq_num;
                    tbl_limit[i] = q.max_count;
                    tbl_ival[i] = q.interval;
                    if (!tbl_halted) begin
                        tbl_count[i] = 1;
                        tbl_armed[i] = 1;
                        tbl_left[i] = q.interval;
                        expected_rsps.push_back(mk(K_TRANSMIT, q.msg_type, q.seq_num, 1, 1));
                    end else begin
                        tbl_count[i] = 0;
                        tbl_armed[i] = 0;
                        tbl_left[i] = 0;
                        expected_rsps.push_back(mk(K_PARKED, q.msg_type, q.seq_num, 0, 1));
                    end
                end
            end
            OP_RESP: begin
                // Type zero can never match: the type sought does not wrap.
                if (q.msg_type != 0) begin
                    for (i = 0; i < NSLOT && !hit; i++) begin
                        if (tbl_valid[i] && tbl_type[i] == q.msg_type - 8'd1 &&
                            tbl_seq[i] == q.seq_num) begin
                            tbl_valid[i] = 0;
                            tbl_armed[i] = 0;
                            expected_rsps.push_back(mk(K_MATCHED, tbl_type[i], tbl_seq[i],
                                                       tbl_count[i], 1));
                            hit = 1;
                        end
                    end
                end
                if (!hit)
                    expected_rsps.push_back(mk(K_UNMATCHED,
                        (q.msg_type != 0) ? q.msg_type - 8'd1 : 8'd0, q.seq_num, 0, 1));
            end
            OP_TICK: begin
                for (i = 0; i < NSLOT; i++) begin
                    if (!tbl_valid[i] || !tbl_armed[i]) continue;
                    if (tbl_left[i] > 1) begin
                        tbl_left[i]--;
                        continue;
                    end
                    if (tbl_count[i] >= tbl_limit[i]) begin
                        tbl_valid[i] = 0;
                        tbl_armed[i] = 0;
                        expected_rsps.push_back(mk(K_GAVE_UP, tbl_type[i], tbl_seq[i],
                                                   tbl_count[i], 0));
                    end else if (tbl_halted) begin
                        tbl_armed[i] = 0;
                        expected_rsps.push_back(mk(K_PARKED, tbl_type[i], tbl_seq[i],
                                                   tbl_count[i], 0));
                    end else begin
                        tbl_count[i] = tbl_count[i] + 4'd1;
                        tbl_left[i] = tbl_ival[i];
                        expected_rsps.push_back(mk(K_TRANSMIT, tbl_type[i], tbl_seq[i],
                                                   tbl_count[i], 0));
                    end
                end
                expected_rsps.push_back(mk(K_DONE, 0, 0, 0, 1));
            end
            OP_CLEAR: begin
                for (i = 0; i < NSLOT; i++) begin
                    tbl_valid[i] = 0;
                    tbl_armed[i] = 0;
                end
                expected_rsps.push_back(mk(K_CLEARED, 0, 0, 0, 1));
            end
            OP_HALT: begin
                if (tbl_halted != q.halt_enable) begin
                    tbl_halted = q.halt_enable;
                    if (!q.halt_enable) begin
                        for (i = 0; i < NSLOT; i++) begin
                            if (!tbl_valid[i] || tbl_armed[i]) continue;
                            if (tbl_count[i] < tbl_limit[i]) begin
                                tbl_count[i] = tbl_count[i] + 4'd1;
                                expected_rsps.push_back(mk(K_TRANSMIT, tbl_type[i],
                                                           tbl_seq[i], tbl_count[i], 0));
                            end
                            tbl_armed[i] = 1;
                            tbl_left[i] = tbl_ival[i];
                        end
                    end
                end
                expected_rsps.push_back(mk(K_DONE, 0, 0, 0, 1));
            end
            default: ;
        endcase
    endtask

    // Valid stays high after an accept so that the next request can follow at once;
    // it drops only for an idle burst or when draining.
    task automatic send_request(input t_req q);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.payload <= q;
        req_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        predict_table(q);
        req_sent++;
    endtask

    function automatic t_req build(input t_op op, input int mt, input int sq,
                                   input int mc, input int iv, input int he);
        t_req q;
        q.op = op;
        q.msg_type = 8'(mt);
        q.seq_num = 8'(sq);
        q.max_count = 4'(mc);
        q.interval = 16'(iv);
        q.halt_enable = 1'(he);
        return q;
    endfunction

    function automatic t_req random_request();
        t_req q;
        q = '0;
        q.op = 3'($urandom_range(0, 7));
        q.msg_type = 8'($urandom);
        q.seq_num = 8'($urandom);
        q.max_count = 4'($urandom);
        q.interval = 16'($urandom);
        q.halt_enable = 1'($urandom);
        return q;
    endfunction

    // Receiver: random idle bursts, plus a long hold-off when requested.
    always @(posedge i_clk) begin
        if (in_reset) begin
            rsp_ch.ready <= 1'b0;
        end else if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
        end else if (rsp_idle > 0) begin
            rsp_idle--;
            rsp_ch.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_idle = $urandom_range(0, 4);
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (!in_reset && rsp_ch.valid && rsp_ch.ready) begin
            rsp_seen++;
            if (expected_rsps.size() == 0) begin
                report_mismatch("unexpected result", rsp_ch.payload, '0);
            end else begin
                want = expected_rsps.pop_front();
                if (rsp_ch.payload.kind !== want.kind)
                    report_mismatch("kind", rsp_ch.payload, want);
                else if (rsp_ch.payload.out_msg_type !== want.out_msg_type)
                    report_mismatch("msg_type", rsp_ch.payload, want);
                else if (rsp_ch.payload.out_seq_num !== want.out_seq_num)
                    report_mismatch("seq_num", rsp_ch.payload, want);
                else if (rsp_ch.payload.out_count !== want.out_count)
                    report_mismatch("count", rsp_ch.payload, want);
                else if (rsp_ch.payload.last !== want.last)
                    report_mismatch("last", rsp_ch.payload, want);
            end
        end
    end

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (expected_rsps.size() != 0) @(posedge i_clk);
        repeat (NSLOT + 4) @(posedge i_clk);
    endtask

    task automatic test_add_park_resume();
        // Halted after reset: adds park, then resume sends them.
        send_request(build(OP_ADD, 8'h00, 8'h00, 1, 1, 0));
        send_request(build(OP_ADD, 8'hFF, 8'hFF, 15, 16'hFFFF, 0));
        send_request(build(OP_ADD, 8'h10, 8'h20, 0, 0, 0));
        send_request(build(OP_HALT, 0, 0, 0, 0, 1));
        send_request(build(OP_HALT, 0, 0, 0, 0, 0));
        send_request(build(OP_HALT, 0, 0, 0, 0, 0));
        send_request(build(OP_TICK, 0, 0, 0, 0, 0));
        send_request(build(OP_TICK, 0, 0, 0, 0, 0));
        wait_drained();
    endtask

    task automatic test_responses();
        send_request(build(OP_RESP, 8'h00, 8'h00, 0, 0, 0));
        send_request(build(OP_RESP, 8'h00, 8'hFF, 0, 0, 0));
        send_request(build(OP_RESP, 8'h00, 8'hFF, 0, 0, 0));
        send_request(build(OP_ADD, 8'h05, 8'h07, 3, 2, 0));
        send_request(build(OP_ADD, 8'h05, 8'h07, 3, 2, 0));
        send_request(build(OP_RESP, 8'h06, 8'h07, 0, 0, 0));
        send_request(build(OP_RESP, 8'h06, 8'h07, 0, 0, 0));
        send_request(build(OP_RESP, 8'h06, 8'h07, 0, 0, 0));
        send_request(build(t_op'(3'd5), 8'h12, 8'h34, 0, 0, 0));
        send_request(build(t_op'(3'd7), 8'hFF, 8'hFF, 4'hF, 16'hFFFF, 1));
        wait_drained();
    endtask

    task automatic test_full_and_clear();
        send_request(build(OP_HALT, 0, 0, 0, 0, 1));
        for (int i = 0; i <= NSLOT; i++)
            send_request(build(OP_ADD, i, i, 2, 1, 0));
        send_request(build(OP_TICK, 0, 0, 0, 0, 0));
        send_request(build(OP_CLEAR, 0, 0, 0, 0, 0));
        wait_drained();
    endtask

    task automatic test_backpressure();
        // The receiver holds off while requests keep coming.
        send_request(build(OP_HALT, 0, 0, 0, 0, 0));
        hold_rsp = 1;
        fork
            begin
                repeat (200) @(posedge i_clk);
                hold_rsp = 0;
            end
            begin
                for (int i = 0; i < 6; i++)
                    send_request(build(OP_ADD, $urandom, $urandom, 3, 1, 0));
                send_request(build(OP_TICK, 0, 0, 0, 0, 0));
            end
        join
        wait_drained();
    endtask

    task automatic test_random_traffic();
        t_req q;
        int pick;
        for (int n = 0; n < 132; n++) begin
            if (n > 105) calm = 1;
            pick = $urandom_range(0, 99);
            q = random_request();
            // Mostly well-formed traffic: short intervals, responses to live entries.
            if (pick < 30) begin
                q.op = OP_ADD;
                q.interval = ($urandom_range(0, 9) == 0) ? q.interval :
                             16'($urandom_range(0, 4));
                q.max_count = ($urandom_range(0, 9) == 0) ? q.max_count :
                              4'($urandom_range(0, 4));
                q.msg_type[7:2] = ($urandom_range(0, 4) == 0) ? q.msg_type[7:2] : 6'd0;
                q.seq_num[7:2] = ($urandom_range(0, 4) == 0) ? q.seq_num[7:2] : 6'd0;
            end else if (pick < 50) begin
                q.op = OP_RESP;
                q.msg_type = 8'($urandom_range(0, 4));
                q.seq_num[7:2] = ($urandom_range(0, 4) == 0) ? q.seq_num[7:2] : 6'd0;
            end else if (pick < 80) begin
                q.op = OP_TICK;
            end else if (pick < 90) begin
                q.op = OP_HALT;
            end else if (pick < 93) begin
                q.op = OP_CLEAR;
            end
            send_request(q);
        end
        wait_drained();
    endtask

    initial begin
        in_reset = 1;
        calm = 0;
        hold_rsp = 0;
        rsp_idle = 0;
        mismatches = 0;
        rsp_seen = 0;
        req_sent = 0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready = 1'b0;
        table_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        in_reset = 0;
        @(posedge i_clk);

        test_add_park_resume();
        test_responses();
        test_full_and_clear();
        test_backpressure();
        test_random_traffic();

        $display("Sent %0d requests, checked %0d results: add, response, tick,", req_sent,
                 rsp_seen);
        $display("clear, halt and resume, full table, long output stall.");
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Timeout with %0d results pending", expected_rsps.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
design/rrt_pkg.sv
design/rrt_if.sv
design/request_retransmit_table_unit.sv
bench/request_retransmit_table_unit_tb.sv
